@@ design/rsc_pkg.sv @@
package rsc_pkg;

  // Command codes as they arrive on req_type
  localparam logic [3:0] REQ_PUSH  = 4'd0;
  localparam logic [3:0] REQ_POP   = 4'd1;
  localparam logic [3:0] REQ_ADD   = 4'd2;
  localparam logic [3:0] REQ_SUB   = 4'd3;
  localparam logic [3:0] REQ_MUL   = 4'd4;
  localparam logic [3:0] REQ_DIV   = 4'd5;
  localparam logic [3:0] REQ_SQRT  = 4'd6;
  localparam logic [3:0] REQ_SIN   = 4'd7;
  localparam logic [3:0] REQ_COS   = 4'd8;
  localparam logic [3:0] REQ_CLEAR = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NEG_SQRT = 3'd3;
  localparam logic [2:0] ST_SAT      = 3'd4;

  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic [33:0]        CORDIC_GAIN = 34'h026DD3B6A;
  localparam logic [3:0]         RED_TOP     = 4'd13;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_SQRT, OP_SIN, OP_COS, OP_CLEAR, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_MUL, S_DIV, S_QUOT,
    S_SQRT, S_ROOT, S_RED, S_FOLD, S_CORDIC, S_TRIG, S_WB, S_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        has;
    logic [2:0]  status;
    logic [4:0]  depth;
  } result_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ design/rsc_ram.sv @@
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rsc_front.sv @@
module rsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         req_type,
  input  logic [31:0]        push_value,
  output logic               cmd_valid,
  output rsc_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);

  rsc_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  rsc_pkg::op_t  op_dec;
  logic          do_push;

  always_comb begin
    case (req_type)
      rsc_pkg::REQ_PUSH:  op_dec = rsc_pkg::OP_PUSH;
      rsc_pkg::REQ_POP:   op_dec = rsc_pkg::OP_POP;
      rsc_pkg::REQ_ADD:   op_dec = rsc_pkg::OP_ADD;
      rsc_pkg::REQ_SUB:   op_dec = rsc_pkg::OP_SUB;
      rsc_pkg::REQ_MUL:   op_dec = rsc_pkg::OP_MUL;
      rsc_pkg::REQ_DIV:   op_dec = rsc_pkg::OP_DIV;
      rsc_pkg::REQ_SQRT:  op_dec = rsc_pkg::OP_SQRT;
      rsc_pkg::REQ_SIN:   op_dec = rsc_pkg::OP_SIN;
      rsc_pkg::REQ_COS:   op_dec = rsc_pkg::OP_COS;
      rsc_pkg::REQ_CLEAR: op_dec = rsc_pkg::OP_CLEAR;
      default:            op_dec = rsc_pkg::OP_NOP;
    endcase
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{op: op_dec, value: push_value};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, cmd_pop};
    end
  end

endmodule

@@ design/rsc_back.sv @@
module rsc_back #(
  parameter int DEPTH        = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  rsc_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              res_valid,
  output rsc_pkg::result_t  res,
  input  logic              res_take
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [5:0] LAST_STEP = 6'(CORDIC_STEPS - 1);
  localparam logic [32:0] TWO_PI_EXT = 33'(rsc_pkg::TWO_PI_Q16);

  rsc_pkg::state_t state, state_next;

  rsc_pkg::op_t       op;
  logic signed [31:0] a, b;
  logic [CW-1:0]      count;
  logic [31:0]        res_value;
  logic               res_has;
  logic [2:0]         res_status;
  logic               wb_we;
  logic [AW-1:0]      wb_addr;
  logic [31:0]        wb_data;
  logic [CW-1:0]      wb_cnt;
  logic [5:0]         iter;

  logic signed [63:0] prod;
  logic [47:0]        dq;
  logic [32:0]        drem;
  logic [47:0]        nq;
  logic [27:0]        srem;
  logic [23:0]        root;
  logic [32:0]        m;
  logic               ang_neg;
  logic               trig_neg;
  logic signed [33:0] x, y, z;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;

  logic               is_bin, is_un, few, short_cmd;
  logic signed [32:0] sum33, dif33;
  logic [32:0]        sum_sat, dif_sat;
  logic signed [63:0] prod_sh;
  logic [32:0]        drem_sh;
  logic               dbit;
  logic [27:0]        srem_sh, strial;
  logic [32:0]        red_c;
  logic signed [20:0] r0, r1, r2;
  logic               fold_neg;
  logic signed [33:0] xs, ys, atan_v, trig_t;
  logic [47:0]        qmag;
  logic               qneg;

  function automatic logic [32:0] sat33(input logic signed [32:0] s);
    // bit 32 flags saturation
    if (s[32] != s[31]) begin
      return {1'b1, s[32] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX};
    end
    return {1'b0, s[31:0]};
  endfunction

  rsc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wb_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    is_bin = (cmd.op == rsc_pkg::OP_ADD) || (cmd.op == rsc_pkg::OP_SUB) ||
             (cmd.op == rsc_pkg::OP_MUL) || (cmd.op == rsc_pkg::OP_DIV);
    is_un  = (cmd.op == rsc_pkg::OP_POP) || (cmd.op == rsc_pkg::OP_SQRT) ||
             (cmd.op == rsc_pkg::OP_SIN) || (cmd.op == rsc_pkg::OP_COS);
    few    = (is_bin && count < CW'(2)) || (is_un && count == '0);
    short_cmd = few || !(is_bin || is_un);
  end

  // Arithmetic helpers
  always_comb begin
    sum33   = {a[31], a} + {b[31], b};
    dif33   = {a[31], a} - {b[31], b};
    sum_sat = sat33(sum33);
    dif_sat = sat33(dif33);
    prod_sh = prod >>> 16;
    drem_sh = {drem[31:0], dq[47]};
    dbit    = (drem_sh >= {1'b0, b[31] ? 32'(-b) : 32'(b)});
    srem_sh = {srem[25:0], nq[47:46]};
    strial  = {2'b00, root, 2'b01};
    red_c   = TWO_PI_EXT << iter[3:0];
    r0 = (ang_neg && m != '0) ? rsc_pkg::TWO_PI_Q16 - 21'(m) : 21'(m);
    r1 = (r0 > rsc_pkg::PI_Q16) ? r0 - rsc_pkg::TWO_PI_Q16 : r0;
    fold_neg = 1'b0;
    r2 = r1;
    if (r1 > rsc_pkg::HALF_PI_Q16) begin
      r2 = r1 - rsc_pkg::PI_Q16;
      fold_neg = 1'b1;
    end else if (r1 < -rsc_pkg::HALF_PI_Q16) begin
      r2 = r1 + rsc_pkg::PI_Q16;
      fold_neg = 1'b1;
    end
    xs     = x >>> iter;
    ys     = y >>> iter;
    atan_v = $signed({2'b00, rsc_pkg::atan_q30(iter[4:0])});
    trig_t = ((op == rsc_pkg::OP_COS) ? x : y) >>> 14;
    if (trig_neg) begin
      trig_t = -trig_t;
    end
    qmag = dq;
    qneg = a[31] ^ b[31];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rsc_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = short_cmd ? rsc_pkg::S_WB : rsc_pkg::S_RD_B;
        end
      end
      rsc_pkg::S_RD_B: begin
        if ((op == rsc_pkg::OP_ADD) || (op == rsc_pkg::OP_SUB) ||
            (op == rsc_pkg::OP_MUL) || (op == rsc_pkg::OP_DIV)) begin
          state_next = rsc_pkg::S_RD_A;
        end else begin
          state_next = rsc_pkg::S_EXEC;
        end
      end
      rsc_pkg::S_RD_A: state_next = rsc_pkg::S_EXEC;
      rsc_pkg::S_EXEC: begin
        case (op)
          rsc_pkg::OP_MUL:  state_next = rsc_pkg::S_MUL;
          rsc_pkg::OP_DIV:  state_next = (b == '0) ? rsc_pkg::S_WB : rsc_pkg::S_DIV;
          rsc_pkg::OP_SQRT: state_next = b[31] ? rsc_pkg::S_WB : rsc_pkg::S_SQRT;
          rsc_pkg::OP_SIN,
          rsc_pkg::OP_COS:  state_next = rsc_pkg::S_RED;
          default:          state_next = rsc_pkg::S_WB;
        endcase
      end
      rsc_pkg::S_MUL:  state_next = rsc_pkg::S_WB;
      rsc_pkg::S_DIV:  if (iter == 6'd47) state_next = rsc_pkg::S_QUOT;
      rsc_pkg::S_QUOT: state_next = rsc_pkg::S_WB;
      rsc_pkg::S_SQRT: if (iter == 6'd23) state_next = rsc_pkg::S_ROOT;
      rsc_pkg::S_ROOT: state_next = rsc_pkg::S_WB;
      rsc_pkg::S_RED:  if (iter == '0) state_next = rsc_pkg::S_FOLD;
      rsc_pkg::S_FOLD: state_next = rsc_pkg::S_CORDIC;
      rsc_pkg::S_CORDIC: if (iter == LAST_STEP) state_next = rsc_pkg::S_TRIG;
      rsc_pkg::S_TRIG: state_next = rsc_pkg::S_WB;
      rsc_pkg::S_WB:   state_next = rsc_pkg::S_DONE;
      rsc_pkg::S_DONE: if (res_take) state_next = rsc_pkg::S_IDLE;
      default:         state_next = rsc_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop   = (state == rsc_pkg::S_IDLE) && cmd_valid;
    ram_re    = 1'b0;
    ram_raddr = AW'(count - CW'(1));
    if (state == rsc_pkg::S_IDLE) begin
      ram_re = cmd_valid;
    end else if (state == rsc_pkg::S_RD_B) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(count - CW'(2));
    end
    ram_we    = (state == rsc_pkg::S_WB) && wb_we;
    ram_waddr = wb_addr;
    res_valid = (state == rsc_pkg::S_DONE);
    res       = '{value: res_value, has: res_has, status: res_status, depth: 5'(count)};
  end

  always_ff @(posedge clk) begin
    case (state)
      rsc_pkg::S_IDLE: begin
        op        <= cmd.op;
        res_value <= '0;
        res_has   <= 1'b0;
        wb_data   <= cmd.value;
        if (few) begin
          res_status <= rsc_pkg::ST_FEW;
          wb_we      <= 1'b0;
          wb_cnt     <= count;
          wb_addr    <= AW'(count - CW'(1));
        end else if (cmd.op == rsc_pkg::OP_PUSH) begin
          wb_addr <= AW'(count);
          if (count >= CW'(DEPTH)) begin
            res_status <= rsc_pkg::ST_FULL;
            wb_we      <= 1'b0;
            wb_cnt     <= count;
          end else begin
            res_status <= rsc_pkg::ST_OK;
            wb_we      <= 1'b1;
            wb_cnt     <= count + CW'(1);
          end
        end else begin
          res_status <= rsc_pkg::ST_OK;
          wb_we      <= 1'b0;
          wb_addr    <= is_bin ? AW'(count - CW'(2)) : AW'(count - CW'(1));
          if (cmd.op == rsc_pkg::OP_CLEAR) begin
            wb_cnt <= '0;
          end else if (is_bin || cmd.op == rsc_pkg::OP_POP) begin
            wb_cnt <= count - CW'(1);
          end else begin
            wb_cnt <= count;
          end
        end
      end
      rsc_pkg::S_RD_B: b <= $signed(ram_rdata);
      rsc_pkg::S_RD_A: a <= $signed(ram_rdata);
      rsc_pkg::S_EXEC: begin
        prod <= a * b;
        dq   <= {a[31] ? 32'(-a) : 32'(a), 16'd0};
        drem <= '0;
        nq   <= {b, 16'd0};
        srem <= '0;
        root <= '0;
        m    <= b[31] ? 33'(-{b[31], b}) : {1'b0, b};
        ang_neg <= b[31];
        iter <= (op == rsc_pkg::OP_SIN || op == rsc_pkg::OP_COS) ?
                6'(rsc_pkg::RED_TOP) : '0;
        case (op)
          rsc_pkg::OP_POP: begin
            res_value <= b;
            res_has   <= 1'b1;
          end
          rsc_pkg::OP_ADD: begin
            res_value  <= sum_sat[31:0];
            wb_data    <= sum_sat[31:0];
            res_has    <= 1'b1;
            wb_we      <= 1'b1;
            res_status <= sum_sat[32] ? rsc_pkg::ST_SAT : rsc_pkg::ST_OK;
          end
          rsc_pkg::OP_SUB: begin
            res_value  <= dif_sat[31:0];
            wb_data    <= dif_sat[31:0];
            res_has    <= 1'b1;
            wb_we      <= 1'b1;
            res_status <= dif_sat[32] ? rsc_pkg::ST_SAT : rsc_pkg::ST_OK;
          end
          rsc_pkg::OP_DIV: begin
            if (b == '0) begin
              res_value  <= a[31] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX;
              wb_data    <= a[31] ? rsc_pkg::SAT_MIN : rsc_pkg::SAT_MAX;
              res_has    <= 1'b1;
              wb_we      <= 1'b1;
              res_status <= rsc_pkg::ST_SAT;
            end
          end
          rsc_pkg::OP_SQRT: begin
            if (b[31]) begin
              res_status <= rsc_pkg::ST_NEG_SQRT;
            end
          end
          default: ;
        endcase
      end
      rsc_pkg::S_MUL: begin
        res_has <= 1'b1;
        wb_we   <= 1'b1;
        if (prod_sh > 64'(rsc_pkg::SAT_MAX)) begin
          res_value  <= rsc_pkg::SAT_MAX;
          wb_data    <= rsc_pkg::SAT_MAX;
          res_status <= rsc_pkg::ST_SAT;
        end else if (prod_sh < 64'(rsc_pkg::SAT_MIN)) begin
          res_value  <= rsc_pkg::SAT_MIN;
          wb_data    <= rsc_pkg::SAT_MIN;
          res_status <= rsc_pkg::ST_SAT;
        end else begin
          res_value <= prod_sh[31:0];
          wb_data   <= prod_sh[31:0];
        end
      end
      rsc_pkg::S_DIV: begin
        // one quotient bit per cycle, restoring
        drem <= dbit ? drem_sh - {1'b0, b[31] ? 32'(-b) : 32'(b)} : drem_sh;
        dq   <= {dq[46:0], dbit};
        iter <= iter + 6'd1;
      end
      rsc_pkg::S_QUOT: begin
        res_has <= 1'b1;
        wb_we   <= 1'b1;
        if (qneg && qmag > 48'h0000_8000_0000) begin
          res_value  <= rsc_pkg::SAT_MIN;
          wb_data    <= rsc_pkg::SAT_MIN;
          res_status <= rsc_pkg::ST_SAT;
        end else if (!qneg && qmag > 48'h0000_7FFF_FFFF) begin
          res_value  <= rsc_pkg::SAT_MAX;
          wb_data    <= rsc_pkg::SAT_MAX;
          res_status <= rsc_pkg::ST_SAT;
        end else begin
          res_value <= qneg ? 32'(-qmag[31:0]) : qmag[31:0];
          wb_data   <= qneg ? 32'(-qmag[31:0]) : qmag[31:0];
        end
      end
      rsc_pkg::S_SQRT: begin
        // two radicand bits per cycle
        if (srem_sh >= strial) begin
          srem <= srem_sh - strial;
          root <= {root[22:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[22:0], 1'b0};
        end
        nq   <= {nq[45:0], 2'b00};
        iter <= iter + 6'd1;
      end
      rsc_pkg::S_ROOT: begin
        res_value <= {8'd0, root};
        wb_data   <= {8'd0, root};
        res_has   <= 1'b1;
        wb_we     <= 1'b1;
      end
      rsc_pkg::S_RED: begin
        // strip multiples of two pi, largest first
        if (m >= red_c) begin
          m <= m - red_c;
        end
        iter <= iter - 6'd1;
      end
      rsc_pkg::S_FOLD: begin
        trig_neg <= fold_neg;
        z        <= 34'(r2) <<< 14;
        x        <= $signed(rsc_pkg::CORDIC_GAIN);
        y        <= '0;
        iter     <= '0;
      end
      rsc_pkg::S_CORDIC: begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_v;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_v;
        end
        iter <= iter + 6'd1;
      end
      rsc_pkg::S_TRIG: begin
        res_value <= trig_t[31:0];
        wb_data   <= trig_t[31:0];
        res_has   <= 1'b1;
        wb_we     <= 1'b1;
      end
      default: ;
    endcase

    if (rst) begin
      state <= rsc_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == rsc_pkg::S_WB) begin
        count <= wb_cnt;
      end
    end
  end

endmodule

@@ design/rpn_stack_calculator.sv @@
// Stack calculator on signed Q16.16 values.
// Input channel: present req_type and push_value with push high; the item is
// taken on a clock edge where push is high and full is low. A two-entry
// command queue sits in front, so up to two items can wait while one runs.
// Result channel: while empty is low, result_value, has_value, status and
// depth_now hold the oldest result; pop high on a clock edge takes it.
// Every item gives exactly one result, in order.
// Engine steps per item: div works out 48 quotient bits, one per cycle;
// sqrt 24 root bits, one per cycle; sin/cos runs 14 range-reduction steps
// and then CORDIC_STEPS CORDIC rotations, one per cycle. Items run one at
// a time: the engine takes a new item only after the result of the last
// one has been handed to the output register.
// The stack lives in a single-port-write, single-port-read RAM; operands are
// read one per cycle.
// Synchronous reset (rst) empties stack, command queue and output register.
// If the receiver stalls, the finished result is held in the output register,
// the engine holds the next result, and then the command queue fills and
// raises full.
module rpn_stack_calculator #(
  parameter int DEPTH        = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         req_type,
  input  logic signed [31:0] push_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] result_value,
  output logic               has_value,
  output logic [2:0]         status,
  output logic [4:0]         depth_now
);

  logic             cmd_valid;
  rsc_pkg::cmd_t    cmd;
  logic             cmd_pop;
  logic             res_valid;
  rsc_pkg::result_t res;
  logic             res_take;
  logic             out_full;
  rsc_pkg::result_t out_q;

  rsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  rsc_back #(.DEPTH(DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!out_full || pop);
  assign empty    = !out_full;

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_take) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  assign result_value = out_q.value;
  assign has_value    = out_q.has;
  assign status       = out_q.status;
  assign depth_now    = out_q.depth;

endmodule

@@ tb/sv/rpn_stack_calculator_tb.sv @@
`timescale 1ns / 100ps

module rpn_stack_calculator_tb;

  localparam int DEPTH = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int N_RANDOM = 1700;

  typedef struct {
    logic signed [31:0] value;
    logic               has;
    logic [2:0]         status;
    logic [4:0]         depth;
  } calc_result_t;

  typedef struct {
    logic [3:0]         req;
    logic signed [31:0] val;
    logic               fixed;  // expected result typed in below
    calc_result_t       res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [3:0]         req_type = '0;
  logic signed [31:0] push_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] result_value;
  logic               has_value;
  logic [2:0]         status;
  logic [4:0]         depth_now;

  rpn_stack_calculator #(.DEPTH(DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .push_value(push_value), .empty(empty), .pop(pop),
    .result_value(result_value), .has_value(has_value), .status(status),
    .depth_now(depth_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] calc_stack [DEPTH];
  int unsigned        calc_count;
  calc_result_t       expected_results [$];
  int                 mismatch_count = 0;
  bit                 stim_done = 1'b0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return rsc_pkg::SAT_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return rsc_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] arctan_step(int i);
    logic [31:0] t [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000};
    return t[i];
  endfunction

  function automatic logic signed [31:0] rotate_trig(logic signed [31:0] angle,
                                                      bit want_cos);
    longint r, x, y, z, nx;
    bit     flip;
    r = longint'(angle) % 411775;
    flip = 1'b0;
    x = 64'h26DD3B6A;
    y = 0;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    if (r > 102944) begin
      r -= 205887;
      flip = 1'b1;
    end else if (r < -102944) begin
      r += 205887;
      flip = 1'b1;
    end
    z = r * 16384;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(arctan_step(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(arctan_step(i));
      end
      x = nx;
    end
    r = floor_shift(want_cos ? x : y, 14);
    if (flip) r = -r;
    return r[31:0];
  endfunction

  function automatic calc_result_t run_command(logic [3:0] req, logic signed [31:0] pv);
    calc_result_t res;
    longint       a, b;
    bit           sat;
    logic signed [31:0] v;
    res = '{value: '0, has: 1'b0, status: rsc_pkg::ST_OK, depth: '0};
    sat = 1'b0;
    case (req)
      rsc_pkg::REQ_PUSH: begin
        if (calc_count >= DEPTH) res.status = rsc_pkg::ST_FULL;
        else calc_stack[calc_count++] = pv;
      end
      rsc_pkg::REQ_POP: begin
        if (calc_count == 0) res.status = rsc_pkg::ST_FEW;
        else begin
          res.value = calc_stack[--calc_count];
          res.has = 1'b1;
        end
      end
      rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB, rsc_pkg::REQ_MUL, rsc_pkg::REQ_DIV: begin
        if (calc_count < 2) res.status = rsc_pkg::ST_FEW;
        else begin
          a = calc_stack[calc_count-2];
          b = calc_stack[calc_count-1];
          if (req == rsc_pkg::REQ_ADD) v = clamp32(a + b, sat);
          else if (req == rsc_pkg::REQ_SUB) v = clamp32(a - b, sat);
          else if (req == rsc_pkg::REQ_MUL) v = clamp32(floor_shift(a * b, 16), sat);
          else if (b == 0) begin
            sat = 1'b1;
            v = (a >= 0) ? rsc_pkg::SAT_MAX : rsc_pkg::SAT_MIN;
          end else v = clamp32((a * 65536) / b, sat);
          calc_count--;
          calc_stack[calc_count-1] = v;
          res.value = v;
          res.has = 1'b1;
          if (sat) res.status = rsc_pkg::ST_SAT;
        end
      end
      rsc_pkg::REQ_SQRT, rsc_pkg::REQ_SIN, rsc_pkg::REQ_COS: begin
        if (calc_count == 0) res.status = rsc_pkg::ST_FEW;
        else begin
          v = calc_stack[calc_count-1];
          if (req == rsc_pkg::REQ_SQRT) begin
            if (v < 0) res.status = rsc_pkg::ST_NEG_SQRT;
            else begin
              res.value = floor_root({16'd0, v, 16'd0});
              res.has = 1'b1;
            end
          end else begin
            res.value = rotate_trig(v, req == rsc_pkg::REQ_COS);
            res.has = 1'b1;
          end
          if (res.has) calc_stack[calc_count-1] = res.value;
        end
      end
      rsc_pkg::REQ_CLEAR: calc_count = 0;
      default: ;
    endcase
    res.depth = calc_count[4:0];
    return res;
  endfunction

  // Directed table; rows with fixed set carry a hand-written result
  stim_row_t directed [] = '{
    '{rsc_pkg::REQ_POP,   32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd0}},
    '{rsc_pkg::REQ_ADD,   32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd0}},
    '{rsc_pkg::REQ_SQRT,  32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd0}},
    '{rsc_pkg::REQ_SIN,   32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd0}},
    '{4'd12,              32'sd7, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_PUSH,  rsc_pkg::SAT_MAX, 1'b1,
      '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd1}},
    '{rsc_pkg::REQ_DIV,   32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd1}},
    '{rsc_pkg::REQ_PUSH,  rsc_pkg::SAT_MAX, 1'b1,
      '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd2}},
    '{rsc_pkg::REQ_ADD,   32'sd0, 1'b1,
      '{rsc_pkg::SAT_MAX, 1'b1, rsc_pkg::ST_SAT, 5'd1}},
    '{rsc_pkg::REQ_PUSH,  32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd2}},
    '{rsc_pkg::REQ_DIV,   32'sd0, 1'b1,
      '{rsc_pkg::SAT_MAX, 1'b1, rsc_pkg::ST_SAT, 5'd1}},
    '{rsc_pkg::REQ_PUSH,  rsc_pkg::SAT_MIN, 1'b1,
      '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd2}},
    '{rsc_pkg::REQ_SUB,   32'sd0, 1'b1,
      '{rsc_pkg::SAT_MAX, 1'b1, rsc_pkg::ST_SAT, 5'd1}},
    '{rsc_pkg::REQ_PUSH,  rsc_pkg::SAT_MIN, 1'b1,
      '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd2}},
    '{rsc_pkg::REQ_PUSH,  32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd3}},
    '{rsc_pkg::REQ_DIV,   32'sd0, 1'b1,
      '{rsc_pkg::SAT_MIN, 1'b1, rsc_pkg::ST_SAT, 5'd2}},
    '{rsc_pkg::REQ_SQRT,  32'sd0, 1'b1,
      '{32'sd0, 1'b0, rsc_pkg::ST_NEG_SQRT, 5'd2}},
    '{rsc_pkg::REQ_MUL,   32'sd0, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_COS,   32'sd0, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_PUSH,  32'sd65536, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_SIN,   32'sd0, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_PUSH,  32'sd262144, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_SQRT,  32'sd0, 1'b0, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_CLEAR, 32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_OK, 5'd0}},
    '{rsc_pkg::REQ_POP,   32'sd0, 1'b1, '{32'sd0, 1'b0, rsc_pkg::ST_FEW, 5'd0}}
  };

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      2: return $urandom_range(0, 1) ? rsc_pkg::SAT_MAX : rsc_pkg::SAT_MIN;
      3: return 32'sd0;
      4: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 1700000)) - 32'sd850000;
    endcase
  endfunction

  function automatic logic [3:0] pick_req(int unsigned cnt);
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) return rsc_pkg::REQ_CLEAR;
    if (k < 4) return 4'($urandom_range(10, 15));
    if (cnt < 3 && k < 60) return rsc_pkg::REQ_PUSH;
    if (cnt >= DEPTH - 1 && k < 40)
      return 4'($urandom_range(rsc_pkg::REQ_POP, rsc_pkg::REQ_COS));
    if (k < 40) return rsc_pkg::REQ_PUSH;
    return 4'($urandom_range(rsc_pkg::REQ_POP, rsc_pkg::REQ_COS));
  endfunction

  task automatic send_item(logic [3:0] req, logic signed [31:0] val);
    push <= 1'b1;
    req_type <= req;
    push_value <= val;
    do @(posedge clk); while (full);
  endtask

  task automatic add_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      req_type <= 4'($urandom);
      push_value <= $urandom;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stimulus: predictions are queued in the order the items are sent
  initial begin
    calc_result_t r;
    logic [3:0]   req;
    logic signed [31:0] val;
    calc_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      r = run_command(directed[i].req, directed[i].val);
      if (directed[i].fixed) r = directed[i].res;
      send_item(directed[i].req, directed[i].val);
      expected_results.push_back(r);
      add_gap();
    end
    // Fill to the top once so that push on a full stack happens
    for (int i = 0; i < DEPTH + 2; i++) begin
      val = pick_value();
      expected_results.push_back(run_command(rsc_pkg::REQ_PUSH, val));
      send_item(rsc_pkg::REQ_PUSH, val);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      req = pick_req(calc_count);
      val = pick_value();
      r = run_command(req, val);
      send_item(req, val);
      expected_results.push_back(r);
      add_gap();
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls on pop
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    calc_result_t e;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result value=%0d", result_value);
      end else begin
        e = expected_results.pop_front();
        if (result_value !== e.value || has_value !== e.has ||
            status !== e.status || depth_now !== e.depth) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp val=%0d has=%0d st=%0d depth=%0d, %s",
                     e.value, e.has, e.status, e.depth,
                     $sformatf("got val=%0d has=%0d st=%0d depth=%0d",
                               result_value, has_value, status, depth_now));
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
